// ===== rtl/prrq_pkg.sv =====
// Shared constants and types of the priority round-robin queues unit.
package prrq_pkg;

  localparam int LEVELS = 7;
  localparam int DEPTH  = 16;

  localparam int LVL_W  = 3;
  localparam int PID_W  = 16;
  localparam int POS_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORDS  = LEVELS * DEPTH;
  localparam int ADDR_W = $clog2(WORDS);
  localparam int STAT_W = 2;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ADDED = 2'd0,
    ST_GIVEN = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

endpackage

// ===== rtl/priority_round_robin_queues_unit.sv =====
// Priority round-robin queues: top level with per-level control and id memory.
// Pipeline: two register stages; an accepted command moves from stage 1 to the output register.
// Throughput: one transaction per cycle unless m_tready stalls; per-level control sits in registers
//   and the id memory is accessed once per transaction, so back-to-back commands need no forwarding.
// Reset (rst, synchronous, active high) empties every level and the pipeline;
//   the id memory is not cleared, slots are read only after being written.
module priority_round_robin_queues_unit
  import prrq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input transactions
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PID_W-1:0]      s_tdata,   // [15:0] pid
  input  logic [LVL_W:0]        s_tuser,   // [0] command, [3:1] priority_req
  // result transactions
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PID_W-1:0]      m_tdata,   // [15:0] pid_out
  output logic [STAT_W-1:0]     m_tuser    // [1:0] status
);

  // Per-level control state
  logic [CNT_W-1:0] level_count   [LEVELS];
  logic [POS_W-1:0] level_cursor  [LEVELS];
  logic             level_started [LEVELS];

  // Stage 1: memory access in flight
  logic    s1_valid;
  status_t s1_status;
  logic    s1_read;

  // Output register
  logic             out_valid;
  status_t          out_status;
  logic [PID_W-1:0] out_pid;

  logic              accept;
  logic              s1_adv;
  cmd_t              cmd;
  logic [LVL_W-1:0]  lvl;
  logic              lvl_ok;
  logic [LVL_W-1:0]  idx;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  cur_inc;
  logic [POS_W-1:0]  pos;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] addr;
  logic              do_write;
  logic              do_read;
  status_t           status_new;
  logic [PID_W-1:0]  rdata;

  assign cmd = cmd_t'(s_tuser[0]);
  assign lvl = s_tuser[LVL_W:1];

  // Pipeline handshake: stage 1 moves on whenever the output register frees up
  assign s1_adv   = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || s1_adv;
  assign accept   = s_tvalid && s_tready;

  // Decode of one command against its level's control state
  always_comb begin
    lvl_ok     = (32'(lvl) < LEVELS);
    idx        = lvl_ok ? lvl : '0;
    n          = level_count[idx];
    cur_inc    = CNT_W'(level_cursor[idx]) + CNT_W'(1);
    do_write   = 1'b0;
    do_read    = 1'b0;
    pos        = '0;
    status_new = ST_EMPTY;
    if (cmd == CMD_ADD) begin
      if (lvl_ok && (n < CNT_W'(DEPTH))) begin
        do_write   = 1'b1;
        pos        = n[POS_W-1:0];
        status_new = ST_ADDED;
      end else begin
        status_new = ST_FULL;
      end
    end else begin
      if (lvl_ok && (n != '0)) begin
        do_read    = 1'b1;
        status_new = ST_GIVEN;
        // first take gives the head, later ones rotate and wrap at the tail
        if (!level_started[idx] || (cur_inc >= n)) begin
          pos = '0;
        end else begin
          pos = cur_inc[POS_W-1:0];
        end
      end else begin
        status_new = ST_EMPTY;
      end
    end
    base = ADDR_W'(idx) * ADDR_W'(DEPTH);
    addr = base + ADDR_W'(pos);
  end

  prrq_ram #(
    .DATA_W (PID_W),
    .WORDS  (WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (accept && do_write),
    .waddr (addr),
    .wdata (s_tdata),
    .re    (accept && do_read),
    .raddr (addr),
    .rdata (rdata)
  );

  // Level control updates at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        level_count[i]   <= '0;
        level_cursor[i]  <= '0;
        level_started[i] <= 1'b0;
      end
    end else if (accept) begin
      if (do_write) begin
        level_count[idx] <= n + CNT_W'(1);
      end
      if (do_read) begin
        level_cursor[idx]  <= pos;
        level_started[idx] <= 1'b1;
      end
    end
  end

  // Stage 1 and output register; read data holds while stage 1 stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status <= status_new;
      s1_read   <= do_read;
    end
    if (s1_adv) begin
      out_status <= s1_status;
      out_pid    <= s1_read ? rdata : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_pid;
  assign m_tuser  = out_status;

endmodule

// ===== rtl/prrq_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read data.
module prrq_ram #(
  parameter int DATA_W = 16,
  parameter int WORDS  = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/sv/priority_round_robin_queues_unit_test.sv =====
// Self-checking testbench for the priority round-robin queues unit.
module priority_round_robin_queues_unit_test
  import prrq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 250;   // long receiver hold-off to back the block up
  localparam int DRAIN_LIMIT = 4000;  // cycles allowed for outstanding results at the end
  localparam int N_DIR_ROWS  = 12;

  // one result transaction
  typedef struct packed {
    status_t          status;
    logic [PID_W-1:0] pid;
  } outcome_t;

  // directed stimulus row; a typed row carries its own expected result,
  // the others are checked against the predictor
  typedef struct packed {
    cmd_t             cmd;
    logic [LVL_W-1:0] lvl;
    logic [PID_W-1:0] pid;
    logic [PID_W-1:0] pid_step;  // added to pid on each repeat
    logic [7:0]       reps;
    bit               typed;
    status_t          status;
    logic [PID_W-1:0] pid_exp;
  } dir_row_t;

  logic              clk;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [PID_W-1:0]  s_tdata  = '0;  // [15:0] pid
  logic [LVL_W:0]    s_tuser  = '0;  // [0] command, [3:1] priority_req
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [PID_W-1:0]  m_tdata;        // [15:0] pid_out
  logic [STAT_W-1:0] m_tuser;        // [1:0] status

  priority_round_robin_queues_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // predictor state: id memory and per-level count, cursor and started flag
  logic [PID_W-1:0] id_mem      [WORDS];
  logic [CNT_W-1:0] fill_cnt    [LEVELS];
  logic [POS_W-1:0] rot_pos     [LEVELS];
  bit               rot_started [LEVELS];

  outcome_t outcomes_due[$];
  dir_row_t dir_rows [N_DIR_ROWS];

  int  fails        = 0;
  int  tx_idle_pct  = 0;    // percent of cycles the sender leaves idle
  int  rx_stall_pct = 0;    // percent of cycles the receiver stalls
  bit  hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic record_failure(input string msg);
    fails++;
    if (fails <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Applies one command to the predictor state and returns its result.
  function automatic outcome_t queue_outcome(cmd_t c, logic [LVL_W-1:0] l,
                                             logic [PID_W-1:0] p);
    outcome_t o;
    int       n;
    int       pos;
    o.pid = '0;
    if (int'(l) >= LEVELS) begin
      // no list behind this level
      o.status = (c == CMD_ADD) ? ST_FULL : ST_EMPTY;
      return o;
    end
    n = int'(fill_cnt[l]);
    if (c == CMD_ADD) begin
      if (n >= DEPTH) begin
        o.status = ST_FULL;
      end else begin
        id_mem[int'(l) * DEPTH + n] = p;
        fill_cnt[l] = CNT_W'(n + 1);
        o.status = ST_ADDED;
      end
      return o;
    end
    if (n == 0) begin
      o.status = ST_EMPTY;
      return o;
    end
    if (!rot_started[l]) begin
      pos = 0;
      rot_started[l] = 1'b1;
    end else begin
      pos = int'(rot_pos[l]) + 1;
      if (pos >= n) pos = 0;
    end
    rot_pos[l] = POS_W'(pos);
    o.status = ST_GIVEN;
    o.pid    = id_mem[int'(l) * DEPTH + pos];
    return o;
  endfunction

  // Offers one transaction, with random idle cycles ahead of it, and logs
  // its expected result once it is accepted.
  task automatic send_txn(input cmd_t c, input logic [LVL_W-1:0] l,
                          input logic [PID_W-1:0] p, input bit typed,
                          input outcome_t typed_res);
    outcome_t pred;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    s_tuser  <= {l, c};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pred = queue_outcome(c, l, p);
    outcomes_due.push_back(typed ? typed_res : pred);
  endtask

  // Mostly next commands, so rotation runs over levels of every fill;
  // a few go to the level past the last one.
  task automatic send_random(input int n);
    cmd_t             c;
    logic [LVL_W-1:0] l;
    logic [PID_W-1:0] p;
    repeat (n) begin
      if ($urandom_range(99) < 6) l = LVL_W'(LEVELS);
      else l = LVL_W'($urandom_range(LEVELS - 1));
      c = ($urandom_range(99) < 12) ? CMD_ADD : CMD_NEXT;
      p = PID_W'($urandom);
      send_txn(c, l, p, 1'b0, '0);
    end
  endtask

  // receiver ready: random stalls, plus one long hold-off on request
  initial begin : rx_ready_gen
    int hold_left;
    bit hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (outcomes_due.size() == 0) begin
        record_failure($sformatf("unexpected result status=%0d pid_out=%h",
                                 m_tuser, m_tdata));
      end else begin
        want = outcomes_due.pop_front();
        if (m_tuser !== want.status)
          record_failure($sformatf("status expected %0d got %0d",
                                   want.status, m_tuser));
        if (m_tdata !== want.pid)
          record_failure($sformatf("pid_out expected %h got %h",
                                   want.pid, m_tdata));
      end
    end
  end

  initial begin : stimulus
    dir_row_t row;
    outcome_t typed_res;
    int       wait_cnt;

    // next on an empty level, then both commands on the level past the last
    dir_rows[0]  = '{CMD_NEXT, 3'd0, 16'h0000, 16'h0000, 8'd1,  1'b1, ST_EMPTY, 16'h0000};
    dir_rows[1]  = '{CMD_ADD,  3'd7, 16'hFFFF, 16'h0000, 8'd1,  1'b1, ST_FULL,  16'h0000};
    dir_rows[2]  = '{CMD_NEXT, 3'd7, 16'hFFFF, 16'h0000, 8'd1,  1'b1, ST_EMPTY, 16'h0000};
    // fill level 2 with 0000, 1111 .. FFFF, then one append too many
    dir_rows[3]  = '{CMD_ADD,  3'd2, 16'h0000, 16'h1111, 8'd16, 1'b1, ST_ADDED, 16'h0000};
    dir_rows[4]  = '{CMD_ADD,  3'd2, 16'h1234, 16'h0000, 8'd1,  1'b1, ST_FULL,  16'h0000};
    // first next gives the head; pid is ignored on next
    dir_rows[5]  = '{CMD_NEXT, 3'd2, 16'hFFFF, 16'h0000, 8'd1,  1'b1, ST_GIVEN, 16'h0000};
    dir_rows[6]  = '{CMD_NEXT, 3'd2, 16'h0000, 16'h0000, 8'd1,  1'b1, ST_GIVEN, 16'h1111};
    dir_rows[7]  = '{CMD_NEXT, 3'd2, 16'h0000, 16'h0000, 8'd1,  1'b0, ST_ADDED, 16'h0000};
    // a single id on the top level keeps coming back
    dir_rows[8]  = '{CMD_ADD,  3'd6, 16'hA5A5, 16'h0000, 8'd1,  1'b1, ST_ADDED, 16'h0000};
    dir_rows[9]  = '{CMD_NEXT, 3'd6, 16'h0000, 16'h0000, 8'd2,  1'b1, ST_GIVEN, 16'hA5A5};
    // an id appended later joins the rotation
    dir_rows[10] = '{CMD_ADD,  3'd6, 16'h5A5A, 16'h0000, 8'd1,  1'b0, ST_ADDED, 16'h0000};
    dir_rows[11] = '{CMD_NEXT, 3'd6, 16'h0000, 16'h0000, 8'd2,  1'b0, ST_ADDED, 16'h0000};

    for (int i = 0; i < LEVELS; i++) begin
      fill_cnt[i]    = '0;
      rot_pos[i]     = '0;
      rot_started[i] = 1'b0;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      typed_res.status = row.status;
      typed_res.pid    = row.pid_exp;
      for (int k = 0; k < int'(row.reps); k++)
        send_txn(row.cmd, row.lvl, PID_W'(row.pid + k * row.pid_step), row.typed,
                 typed_res);
    end

    // random traffic under each idling pattern
    tx_idle_pct = 0;  rx_stall_pct = 0;  send_random(440);
    tx_idle_pct = 82; rx_stall_pct = 0;  send_random(440);
    tx_idle_pct = 0;  rx_stall_pct = 82; send_random(440);
    tx_idle_pct = 19; rx_stall_pct = 19; send_random(440);

    // back-pressure: receiver holds off while the sender keeps offering
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_request = 1'b1;
    send_random(100);
    s_tvalid <= 1'b0;

    wait_cnt = 0;
    while (outcomes_due.size() != 0 && wait_cnt < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (outcomes_due.size() != 0)
      record_failure($sformatf("%0d results never arrived", outcomes_due.size()));
    // room for any stray result behind the pipeline
    repeat (8) @(posedge clk);

    if (fails == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
